FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define TBE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbe: property failed");

// next-cycle implication, ignored while reset is high
`define TBE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbe: property failed");

// next-cycle implication that also holds across reset
`define TBE_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tbe: property failed");

`endif

FILE: rtl/core/tbe_pkg.sv
package tbe_pkg;

  localparam int CHAN_W    = 3;
  localparam int COEF_W    = 17;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [GAIN_W-1:0] gain_t;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  localparam coef_t LOW_COEF_RST  = 17'd5601;
  localparam coef_t HIGH_COEF_RST = 17'd9330;
  localparam gain_t GAIN_RST      = 16'd4096;

  localparam int COEF_FRAC = 16;
  localparam int GAIN_FRAC = 12;
  localparam int POLE_FRAC = 12;
  localparam int MUL_B_W   = COEF_W + 1;

  // four low poles then four high poles per channel
  localparam int STAGE_W = 3;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LAST_LOW  = 4'd3;
  localparam logic [OP_W-1:0] OP_LAST_HIGH = 4'd7;
  localparam logic [OP_W-1:0] OP_LOW_BAND  = 4'd8;
  localparam logic [OP_W-1:0] OP_MID_BAND  = 4'd9;
  localparam logic [OP_W-1:0] OP_HIGH_BAND = 4'd10;

endpackage

FILE: rtl/core/tbe_in_if.sv
interface tbe_in_if #(parameter int SAMPLE_BITS = 24) ();
  import tbe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CHAN_W-1:0]      channel;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

FILE: rtl/core/tbe_out_if.sv
interface tbe_out_if #(parameter int SAMPLE_BITS = 24) ();
  import tbe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CHAN_W-1:0]      channel_out;
  logic [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

FILE: rtl/core/three_band_equalizer.sv
// An accepted sample runs through the states to S_FIN, which loads the result
// into the output register once free; S_IDLE jumps to S_FIN for a channel
// index at or above CHANNELS. Only S_IDLE accepts a sample; the single shared
// 22x18 multiplier forms each of the eleven products as two partial products.
// Reset: synchronous; presets config, clears control and per-channel valid
// flags, so all filter state and history read zero until its channel is written.
module three_band_equalizer #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbe_pkg::CFG_W-1:0]      cfg_data,
  tbe_in_if.sink                         samples,
  tbe_out_if.source                      results
);
  import tbe_pkg::*;

  localparam int SB         = SAMPLE_BITS;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W      = (CH_W > CHAN_W) ? CH_W : CHAN_W;
  localparam int PB         = SB + 16;
  localparam int DW         = PB + 1;
  localparam int LO_W       = DW / 2;
  localparam int HI_W       = DW - LO_W;
  localparam int MA         = HI_W + 1;
  localparam int PPW        = MA + MUL_B_W;
  localparam int AW         = DW + MUL_B_W;
  localparam int SW         = PB + 4;
  localparam int TERMW      = AW - GAIN_FRAC;
  localparam int TW         = TERMW + 2;
  localparam int FW         = TW - POLE_FRAC;
  localparam int HW         = 3 * SB;
  localparam int HIST_DEPTH = 2 ** CH_W;
  localparam int POLE_DEPTH = HIST_DEPTH * (2 ** STAGE_W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_M0   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_BAND = 4'd6;
  localparam logic [3:0] S_TERM = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  coef_t low_coef;
  coef_t high_coef;
  gain_t low_gain;
  gain_t mid_gain;
  gain_t high_gain;

  logic [3:0]          state;
  logic [CHANNELS-1:0] row_valid;
  logic                out_valid;
  logic [CHAN_W-1:0]   out_channel;
  logic [SB-1:0]       out_sample;

  logic [OP_W-1:0]     op;
  logic [CHAN_W-1:0]   chan;
  logic [CH_W-1:0]     ch_idx;
  logic [SB-1:0]       samp;
  logic [PB-1:0]       xr;
  logic [PB-1:0]       p_reg;
  logic [DW-1:0]       opnd;
  logic [PPW-1:0]      pp;
  logic [AW-1:0]       acc;
  logic [PB-1:0]       low_out;
  logic [PB-1:0]       hi_out;
  logic [HW-1:0]       hist_r;
  logic [DW-1:0]       high_r;
  logic [DW-1:0]       mid_r;
  logic [TW-1:0]       total;

  logic                accept;
  logic                in_ok;
  logic                fin_load;
  logic [IDX_W-1:0]    in_wide;
  logic [CH_W-1:0]     in_ch_idx;
  logic [PB-1:0]       x_in;
  logic [PB-1:0]       x_scaled;
  logic [OP_W-1:0]     op_inc;
  logic [CH_W+STAGE_W-1:0] pole_raddr;
  logic [CH_W+STAGE_W-1:0] pole_waddr;
  logic [PB-1:0]       pole_rdata;
  logic [PB-1:0]       pole_rd_val;
  logic [PB-1:0]       pole_new;
  logic [HW-1:0]       hist_rdata;
  logic [HW-1:0]       hist_wdata;
  logic [COEF_W-1:0]   coef_sel;
  logic [MA-1:0]       mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic signed [PPW-1:0] prod;
  logic [AW-1:0]       pp_ext;
  logic [SW-1:0]       upd_sum;
  logic [SW-PB:0]      upd_hi;
  logic [DW-1:0]       delayed_ext;
  logic [TW-1:0]       term_ext;
  logic [FW-1:0]       fin_val;
  logic [FW-SB:0]      fin_hi;
  logic [SB-1:0]       fin_sat;

  assign accept    = samples.valid && samples.ready;
  assign in_wide   = IDX_W'(samples.channel);
  assign in_ch_idx = in_wide[CH_W-1:0];
  assign in_ok     = 32'(samples.channel) < 32'(CHANNELS);
  assign fin_load  = (state == S_FIN) && (!out_valid || results.ready);
  assign op_inc    = op + 1'b1;

  assign x_in     = {{(PB-SB-POLE_FRAC){samples.sample_in[SB-1]}}, samples.sample_in,
                     {POLE_FRAC{1'b0}}};
  assign x_scaled = {{(PB-SB-POLE_FRAC){samp[SB-1]}}, samp, {POLE_FRAC{1'b0}}};

  assign samples.ready       = (state == S_IDLE);
  assign results.valid       = out_valid;
  assign results.channel_out = out_channel;
  assign results.sample_out  = out_sample;

  assign pole_raddr = (state == S_IDLE) ? {in_ch_idx, STAGE_W'(0)}
                                        : {ch_idx, op_inc[STAGE_W-1:0]};
  assign pole_waddr = {ch_idx, op[STAGE_W-1:0]};
  assign pole_rd_val = row_valid[ch_idx] ? pole_rdata : '0;
  assign hist_wdata  = {hist_r[2*SB-1:0], samp};

  tbe_ram #(
    .WIDTH (PB),
    .DEPTH (POLE_DEPTH)
  ) u_pole_ram (
    .clk   (clk),
    .we    (state == S_UPD),
    .waddr (pole_waddr),
    .wdata (pole_new),
    .raddr (pole_raddr),
    .rdata (pole_rdata)
  );

  tbe_ram #(
    .WIDTH (HW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (state == S_BAND),
    .waddr (ch_idx),
    .wdata (hist_wdata),
    .raddr (in_ch_idx),
    .rdata (hist_rdata)
  );

  always_comb begin
    priority if (op <= OP_LAST_LOW) begin
      coef_sel = low_coef;
    end else if (op <= OP_LAST_HIGH) begin
      coef_sel = high_coef;
    end else if (op == OP_LOW_BAND) begin
      coef_sel = {1'b0, low_gain};
    end else if (op == OP_MID_BAND) begin
      coef_sel = {1'b0, mid_gain};
    end else begin
      coef_sel = {1'b0, high_gain};
    end
  end

  assign mul_a = (state == S_M0) ? {{(MA-LO_W){1'b0}}, opnd[LO_W-1:0]}
                                 : {{(MA-HI_W){opnd[DW-1]}}, opnd[DW-1:LO_W]};
  assign mul_b = {1'b0, coef_sel};
  assign prod  = $signed(mul_a) * $signed(mul_b);
  assign pp_ext = {{(AW-PPW){pp[PPW-1]}}, pp};

  always_comb begin
    upd_sum = {{(SW-PB){p_reg[PB-1]}}, p_reg} + {acc[AW-1], acc[AW-1:COEF_FRAC]};
    upd_hi  = upd_sum[SW-1:PB-1];
    if ((&upd_hi) || !(|upd_hi)) begin
      pole_new = upd_sum[PB-1:0];
    end else if (upd_sum[SW-1]) begin
      pole_new = {1'b1, {(PB-1){1'b0}}};
    end else begin
      pole_new = {1'b0, {(PB-1){1'b1}}};
    end
  end

  assign delayed_ext = {{(DW-SB-POLE_FRAC){hist_r[HW-1]}}, hist_r[HW-1:2*SB],
                        {POLE_FRAC{1'b0}}};
  assign term_ext    = {{2{acc[AW-1]}}, acc[AW-1:GAIN_FRAC]};

  always_comb begin
    fin_val = total[TW-1:POLE_FRAC];
    fin_hi  = fin_val[FW-1:SB-1];
    if ((&fin_hi) || !(|fin_hi)) begin
      fin_sat = fin_val[SB-1:0];
    end else if (fin_val[FW-1]) begin
      fin_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      fin_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_coef  <= LOW_COEF_RST;
      high_coef <= HIGH_COEF_RST;
      low_gain  <= GAIN_RST;
      mid_gain  <= GAIN_RST;
      high_gain <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_COEF:  low_coef  <= cfg_data[COEF_W-1:0];
        REG_HIGH_COEF: high_coef <= cfg_data[COEF_W-1:0];
        REG_LOW_GAIN:  low_gain  <= cfg_data[GAIN_W-1:0];
        REG_MID_GAIN:  mid_gain  <= cfg_data[GAIN_W-1:0];
        REG_HIGH_GAIN: high_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= in_ok ? S_DIFF : S_FIN;
          end
        end
        S_DIFF: state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= (op < OP_LOW_BAND) ? S_UPD : S_TERM;
        S_UPD:  state <= (op == OP_LAST_HIGH) ? S_BAND : S_DIFF;
        S_BAND: begin
          row_valid[ch_idx] <= 1'b1;
          state             <= S_M0;
        end
        S_TERM: state <= (op == OP_HIGH_BAND) ? S_FIN : S_M0;
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_channel <= chan;
      out_sample  <= fin_sat;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          chan   <= samples.channel;
          ch_idx <= in_ch_idx;
          samp   <= samples.sample_in;
          xr     <= x_in;
          op     <= '0;
          total  <= '0;
        end
      end
      S_DIFF: begin
        p_reg <= pole_rd_val;
        opnd  <= {xr[PB-1], xr} - {pole_rd_val[PB-1], pole_rd_val};
        if (op == '0) begin
          hist_r <= row_valid[ch_idx] ? hist_rdata : '0;
        end
      end
      S_M0: pp <= prod;
      S_M1: begin
        acc <= pp_ext;
        pp  <= prod;
      end
      S_M2: acc <= acc + (pp_ext << LO_W);
      S_UPD: begin
        xr <= (op == OP_LAST_LOW) ? x_scaled : pole_new;
        if (op == OP_LAST_LOW) begin
          low_out <= pole_new;
        end
        if (op == OP_LAST_HIGH) begin
          hi_out <= pole_new;
        end
        op <= op_inc;
      end
      S_BAND: begin
        opnd   <= {low_out[PB-1], low_out};
        high_r <= delayed_ext - {hi_out[PB-1], hi_out};
        mid_r  <= {hi_out[PB-1], hi_out} - {low_out[PB-1], low_out};
      end
      S_TERM: begin
        total <= ((op == OP_LOW_BAND) ? '0 : total) + term_ext;
        opnd  <= (op == OP_LOW_BAND) ? mid_r : high_r;
        if (op != OP_HIGH_BAND) begin
          op <= op_inc;
        end
      end
      S_FIN: ;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/tbe_ram.sv
module tbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tbe_checker.sv
`include "assert_macros.svh"

module tbe_checker #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tbe_pkg::CHAN_W-1:0] out_channel,
  input logic [SAMPLE_BITS-1:0]     out_sample
);
  import tbe_pkg::*;

  logic bad_channel;
  logic stalled;

  assign bad_channel = 32'(out_channel) >= 32'(CHANNELS);
  assign stalled     = out_valid && !out_ready;

  `TBE_ASSERT_NXT_ALWAYS(a_reset_idle, clk, rst, in_ready && !out_valid)

  `TBE_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  `TBE_ASSERT_IMP(a_bad_channel_zero, clk, rst, out_valid && bad_channel, out_sample == '0)

  `TBE_ASSERT_NXT(a_stall_hold, clk, rst, stalled, out_valid && $stable({out_channel, out_sample}))

endmodule

bind three_band_equalizer tbe_checker #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tbe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_channel (results.channel_out),
  .out_sample  (results.sample_out)
);
